/* design/rki_pkg.sv */
// Shared types, constants and command/status structs for the run-keyed index translator.
`timescale 1ns / 1ps
`default_nettype none

package rki_pkg;

  localparam int KEY_BITS              = 64;
  localparam int POS_FIELD_BITS        = 32;
  localparam int ACTION_BITS           = 3;
  localparam int SLOT_BITS             = 5;
  localparam int RUN_COUNT_BITS        = 6;
  localparam int CFG_INDEX_BITS        = 2;
  localparam int CFG_DATA_BITS         = 64;
  localparam int DEFAULT_MAX_RUNS      = 32;
  localparam int DEFAULT_POSITION_BITS = 32;

  localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_KEY = CFG_INDEX_BITS'(0);
  localparam logic [CFG_INDEX_BITS-1:0] REG_RUN_COUNT   = CFG_INDEX_BITS'(1);

  typedef enum logic [ACTION_BITS-1:0] {
    ACT_WRITE     = 3'd0,
    ACT_I2R       = 3'd1,
    ACT_R2I       = 3'd2,
    ACT_ITER_INIT = 3'd3,
    ACT_ITER_NEXT = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIND,
    ST_RANK,
    ST_LOOKUP,
    ST_ITER,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic load;
    logic key_from_init;
    logic rd_en;
    logic take_key;
    logic rank_step;
    logic lookup_step;
    logic iter_init;
    logic iter_next;
    logic iter_take;
    logic out_load;
    logic out_iter;
    logic out_more;
  } cmd_t;

  typedef struct packed {
    logic ge_start;
    logic lookup_stop;
    logic iter_end;
    logic iter_ge;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

/* design/rki_ifs.sv */
// Input and result channel interfaces with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface rki_in_if;
  logic                               valid;
  logic                               ready;
  logic [rki_pkg::ACTION_BITS-1:0]    action;
  logic [rki_pkg::SLOT_BITS-1:0]      slot;
  logic [rki_pkg::KEY_BITS-1:0]       key;
  logic [rki_pkg::POS_FIELD_BITS-1:0] position;

  modport source (output valid, action, slot, key, position, input ready);
  modport sink   (input valid, action, slot, key, position, output ready);
endinterface

interface rki_out_if;
  logic                               valid;
  logic                               ready;
  logic [rki_pkg::KEY_BITS-1:0]       out_key;
  logic [rki_pkg::POS_FIELD_BITS-1:0] out_index;
  logic                               more;

  modport source (output valid, out_key, out_index, more, input ready);
  modport sink   (input valid, out_key, out_index, more, output ready);
endinterface

`default_nettype wire

/* design/rki_datapath.sv */
// Datapath: config registers, run table memories, scan accumulators, iterator, result register.
`timescale 1ns / 1ps
`default_nettype none

module rki_datapath #(
  parameter int MAX_RUNS      = rki_pkg::DEFAULT_MAX_RUNS,
  parameter int POSITION_BITS = rki_pkg::DEFAULT_POSITION_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rki_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rki_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  input  logic [rki_pkg::SLOT_BITS-1:0]       in_slot,
  input  logic [rki_pkg::KEY_BITS-1:0]        in_key,
  input  logic [rki_pkg::POS_FIELD_BITS-1:0]  in_position,
  input  rki_pkg::cmd_t                       cmd,
  input  logic [((MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1)-1:0] rd_addr,
  output rki_pkg::status_t                    status,
  output logic [$clog2(MAX_RUNS+1)-1:0]       live,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [rki_pkg::KEY_BITS-1:0]        out_key,
  output logic [rki_pkg::POS_FIELD_BITS-1:0]  out_index,
  output logic                                out_more
);

  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;
  localparam int PB = POSITION_BITS;

  logic [rki_pkg::KEY_BITS-1:0]       initial_key;
  logic [rki_pkg::RUN_COUNT_BITS-1:0] run_count;

  logic [rki_pkg::KEY_BITS-1:0] run_keys   [MAX_RUNS];
  logic [PB-1:0]                run_starts [MAX_RUNS];

  logic [rki_pkg::KEY_BITS-1:0] rd_key;
  logic [PB-1:0]                rd_start;

  logic [rki_pkg::KEY_BITS-1:0] qkey;
  logic [PB-1:0]                qpos;
  logic [PB-1:0]                acc;
  logic [PB-1:0]                left;
  logic [rki_pkg::KEY_BITS-1:0] ckey;
  logic [PB-1:0]                cstart;

  logic                         it_before;
  logic [PB-1:0]                it_pos;
  logic [rki_pkg::KEY_BITS-1:0] it_key;

  logic [PB-1:0] pos_w;
  logic [PB-1:0] run_len;
  logic          slot_ok;
  logic          count_gt;

  assign pos_w    = PB'(in_position);
  assign run_len  = rd_start - cstart;
  assign slot_ok  = 32'(in_slot) < 32'(MAX_RUNS);
  assign count_gt = 32'(run_count) > 32'(MAX_RUNS);
  assign live     = count_gt ? CW'(MAX_RUNS) : CW'(run_count);

  assign status.ge_start    = qpos >= rd_start;
  assign status.lookup_stop = (qkey == ckey) && (left < run_len);
  assign status.iter_end    = it_pos >= qpos;
  assign status.iter_ge     = it_pos >= rd_start;
  assign status.out_busy    = out_valid && !out_ready;

  // Config registers, iterator state and result valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      initial_key <= '0;
      run_count   <= '0;
      it_before   <= 1'b1;
      it_pos      <= '0;
      it_key      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == rki_pkg::REG_INITIAL_KEY) begin
          initial_key <= cfg_data;
        end else if (cfg_index == rki_pkg::REG_RUN_COUNT) begin
          run_count <= cfg_data[rki_pkg::RUN_COUNT_BITS-1:0];
        end
      end
      if (cmd.iter_init) begin
        it_before <= 1'b1;
        it_pos    <= '0;
        it_key    <= initial_key;
      end else begin
        if (cmd.iter_next) begin
          if (it_before) begin
            it_before <= 1'b0;
            it_pos    <= '0;
          end else if (it_pos != {PB{1'b1}}) begin
            it_pos <= it_pos + PB'(1);
          end
        end
        if (cmd.iter_take) begin
          it_key <= rd_key;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Run table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && slot_ok) begin
      run_keys[AW'(in_slot)]   <= in_key;
      run_starts[AW'(in_slot)] <= pos_w;
    end
    if (cmd.rd_en) begin
      rd_key   <= run_keys[rd_addr];
      rd_start <= run_starts[rd_addr];
    end
  end

  // Query accumulators and result payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qkey   <= cmd.key_from_init ? initial_key : in_key;
      qpos   <= pos_w;
      acc    <= pos_w;
      left   <= pos_w;
      ckey   <= initial_key;
      cstart <= '0;
    end else begin
      if (cmd.take_key) begin
        qkey <= rd_key;
      end
      if (cmd.rank_step) begin
        if (qkey != ckey) begin
          acc <= acc - run_len;
        end
        ckey   <= rd_key;
        cstart <= rd_start;
      end
      if (cmd.lookup_step) begin
        // Runs of other keys shift the position; runs of the key use up the rank.
        if (qkey != ckey) begin
          acc <= acc + run_len;
        end else begin
          left <= left - run_len;
        end
        ckey   <= rd_key;
        cstart <= rd_start;
      end
    end
    if (cmd.out_load) begin
      out_key   <= cmd.out_iter ? it_key : qkey;
      out_index <= rki_pkg::POS_FIELD_BITS'(cmd.out_iter ? it_pos : acc);
      out_more  <= cmd.out_more;
    end
  end

endmodule

`default_nettype wire

/* design/rki_ctrl.sv */
// Controller: decodes items and sequences the table scans one entry per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rki_ctrl #(
  parameter int MAX_RUNS = rki_pkg::DEFAULT_MAX_RUNS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic [rki_pkg::ACTION_BITS-1:0]   in_action,
  output logic                              in_ready,
  input  logic [$clog2(MAX_RUNS+1)-1:0]     live,
  input  rki_pkg::status_t                  status,
  output rki_pkg::cmd_t                     cmd,
  output logic [((MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1)-1:0] rd_addr
);

  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

  rki_pkg::state_t  state;
  rki_pkg::state_t  state_next;
  rki_pkg::action_t action;

  logic [CW-1:0] p;
  logic [CW-1:0] p_next;
  logic [CW-1:0] upto;
  logic [CW-1:0] upto_next;
  logic [CW-1:0] iter_pair;
  logic [CW-1:0] iter_pair_next;
  logic          more;
  logic          more_next;
  logic          iter_mode;
  logic          iter_mode_next;

  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] p_inc;
  logic [CW-1:0] pair_inc;
  logic [CW-1:0] upto_exit;
  logic          pair_live;

  assign action    = rki_pkg::action_t'(in_action);
  assign in_ready  = (state == rki_pkg::ST_IDLE);
  assign p_inc     = p + CW'(1);
  assign pair_inc  = iter_pair + CW'(1);
  assign pair_live = iter_pair < live;
  assign upto_exit = status.ge_start ? p_inc : p;
  assign rd_addr   = rd_ptr[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rki_pkg::ST_IDLE;
      p         <= '0;
      upto      <= '0;
      iter_pair <= '0;
      more      <= 1'b0;
      iter_mode <= 1'b0;
    end else begin
      state     <= state_next;
      p         <= p_next;
      upto      <= upto_next;
      iter_pair <= iter_pair_next;
      more      <= more_next;
      iter_mode <= iter_mode_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      rki_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (action)
            rki_pkg::ACT_I2R:
              state_next = (live == '0) ? rki_pkg::ST_DONE : rki_pkg::ST_FIND;
            rki_pkg::ACT_R2I:
              state_next = (live == '0) ? rki_pkg::ST_DONE : rki_pkg::ST_LOOKUP;
            rki_pkg::ACT_ITER_NEXT:
              state_next = rki_pkg::ST_ITER;
            default: state_next = rki_pkg::ST_IDLE;
          endcase
        end
      end
      rki_pkg::ST_FIND: begin
        if (status.ge_start && (p_inc < live)) begin
          state_next = rki_pkg::ST_FIND;
        end else if (upto_exit == '0) begin
          state_next = rki_pkg::ST_DONE;
        end else begin
          state_next = rki_pkg::ST_RANK;
        end
      end
      rki_pkg::ST_RANK: begin
        state_next = (p_inc < upto) ? rki_pkg::ST_RANK : rki_pkg::ST_DONE;
      end
      rki_pkg::ST_LOOKUP: begin
        if (!status.lookup_stop && (p_inc < live)) begin
          state_next = rki_pkg::ST_LOOKUP;
        end else begin
          state_next = rki_pkg::ST_DONE;
        end
      end
      rki_pkg::ST_ITER: begin
        if (!status.iter_end && pair_live && status.iter_ge && (pair_inc < live)) begin
          state_next = rki_pkg::ST_ITER;
        end else begin
          state_next = rki_pkg::ST_DONE;
        end
      end
      rki_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          state_next = rki_pkg::ST_IDLE;
        end
      end
      default: state_next = rki_pkg::ST_IDLE;
    endcase
  end

  // Commands and counter updates.
  always_comb begin
    cmd            = '0;
    rd_ptr         = '0;
    p_next         = p;
    upto_next      = upto;
    iter_pair_next = iter_pair;
    more_next      = more;
    iter_mode_next = iter_mode;
    unique case (state)
      rki_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (action)
            rki_pkg::ACT_WRITE: begin
              cmd.wr_en = 1'b1;
            end
            rki_pkg::ACT_I2R: begin
              cmd.load          = 1'b1;
              cmd.key_from_init = 1'b1;
              cmd.rd_en         = (live != '0);
              p_next            = '0;
              upto_next         = '0;
              more_next         = 1'b0;
              iter_mode_next    = 1'b0;
            end
            rki_pkg::ACT_R2I: begin
              cmd.load       = 1'b1;
              cmd.rd_en      = (live != '0);
              p_next         = '0;
              more_next      = 1'b0;
              iter_mode_next = 1'b0;
            end
            rki_pkg::ACT_ITER_INIT: begin
              cmd.iter_init  = 1'b1;
              iter_pair_next = '0;
            end
            rki_pkg::ACT_ITER_NEXT: begin
              // Prefetch the pending table pair while the position advances.
              cmd.load       = 1'b1;
              cmd.iter_next  = 1'b1;
              cmd.rd_en      = pair_live;
              rd_ptr         = iter_pair;
              iter_mode_next = 1'b1;
            end
            default: ;
          endcase
        end
      end
      rki_pkg::ST_FIND: begin
        if (status.ge_start) begin
          cmd.take_key = 1'b1;
          upto_next    = p_inc;
        end
        if (status.ge_start && (p_inc < live)) begin
          cmd.rd_en = 1'b1;
          rd_ptr    = p_inc;
          p_next    = p_inc;
        end else if (upto_exit != '0) begin
          // Restart from pair zero for the rank pass.
          cmd.rd_en = 1'b1;
          rd_ptr    = '0;
          p_next    = '0;
        end
      end
      rki_pkg::ST_RANK: begin
        cmd.rank_step = 1'b1;
        if (p_inc < upto) begin
          cmd.rd_en = 1'b1;
          rd_ptr    = p_inc;
          p_next    = p_inc;
        end
      end
      rki_pkg::ST_LOOKUP: begin
        if (!status.lookup_stop) begin
          cmd.lookup_step = 1'b1;
          if (p_inc < live) begin
            cmd.rd_en = 1'b1;
            rd_ptr    = p_inc;
            p_next    = p_inc;
          end
        end
      end
      rki_pkg::ST_ITER: begin
        if (status.iter_end) begin
          more_next = 1'b0;
        end else begin
          more_next = 1'b1;
          if (pair_live && status.iter_ge) begin
            cmd.iter_take  = 1'b1;
            iter_pair_next = pair_inc;
            if (pair_inc < live) begin
              cmd.rd_en = 1'b1;
              rd_ptr    = pair_inc;
            end
          end
        end
      end
      rki_pkg::ST_DONE: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          cmd.out_more = more;
          cmd.out_iter = iter_mode;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  a_rd_in_table: assert property (@(posedge clk) disable iff (rst)
    cmd.rd_en |-> (rd_ptr < live))
    else $error("table read beyond live pairs");

  a_rank_bound: assert property (@(posedge clk) disable iff (rst)
    (state == rki_pkg::ST_RANK) |-> ((p < upto) && (upto != '0)))
    else $error("rank pass index out of range");

  a_pair_bound: assert property (@(posedge clk) disable iff (rst)
    iter_pair <= CW'(MAX_RUNS))
    else $error("iterator pair beyond table depth");

  a_i2r_start: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_action == rki_pkg::ACT_I2R) && (live != '0))
      |=> (state == rki_pkg::ST_FIND))
    else $error("index lookup did not start its scan");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> ((state == rki_pkg::ST_DONE) && !status.out_busy))
    else $error("result loaded over a pending item");
`endif

endmodule

`default_nettype wire

/* design/run_keyed_index_translator.sv */
// One item at a time; the one-pair-a-cycle table scan sets how long an item takes. Index to
// reference finds the upto pairs at or below the position, then ranks over them; reference to
// index scans up to N = min(run_count, MAX_RUNS) pairs; iterator next scans the pairs it crosses.
// Write pair and iterator init give no result. The next item is taken while a result waits; a
// second result holds until the first leaves. Reset (synchronous): clears config, iterator and
// controller state and result valid; the run table and result payload are not reset.
`timescale 1ns / 1ps
`default_nettype none

module run_keyed_index_translator #(
  parameter int MAX_RUNS      = rki_pkg::DEFAULT_MAX_RUNS,
  parameter int POSITION_BITS = rki_pkg::DEFAULT_POSITION_BITS
) (
  input  logic                               clk,
  input  logic                               rst,
  rki_in_if.sink                             in_item,
  rki_out_if.source                          out_item,
  input  logic                               cfg_we,
  input  logic [rki_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rki_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int CW = $clog2(MAX_RUNS + 1);
  localparam int AW = (MAX_RUNS > 1) ? $clog2(MAX_RUNS) : 1;

  rki_pkg::cmd_t    cmd;
  rki_pkg::status_t status;
  logic [CW-1:0]    live;
  logic [AW-1:0]    rd_addr;

  rki_ctrl #(
    .MAX_RUNS (MAX_RUNS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_item.valid),
    .in_action (in_item.action),
    .in_ready  (in_item.ready),
    .live      (live),
    .status    (status),
    .cmd       (cmd),
    .rd_addr   (rd_addr)
  );

  rki_datapath #(
    .MAX_RUNS      (MAX_RUNS),
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_slot     (in_item.slot),
    .in_key      (in_item.key),
    .in_position (in_item.position),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .status      (status),
    .live        (live),
    .out_ready   (out_item.ready),
    .out_valid   (out_item.valid),
    .out_key     (out_item.out_key),
    .out_index   (out_item.out_index),
    .out_more    (out_item.more)
  );

endmodule

`default_nettype wire
